@@ src/ecp_pkg.sv @@
// ecp_pkg: shared types and constants for the eviction candidate pool
// used by ecp_cell and eviction_candidate_pool; no dependencies
`default_nettype none

package ecp_pkg;

	localparam int POOL_DEPTH_DEF = 16;
	localparam int KEY_W          = 32;
	localparam int DB_W           = 4;
	localparam int SCORE_W        = 32;

	// database numbers at or above this count are rejected
	localparam logic [8:0] DB_COUNT = 9'd16;

	// lfu scores are this base minus the counter byte
	localparam logic [SCORE_W-1:0] LFU_INVERT_BASE = 32'd255;

	// insert outcome codes
	localparam logic [1:0] OUTCOME_DROPPED = 2'd0;
	localparam logic [1:0] OUTCOME_EMPTY   = 2'd1;
	localparam logic [1:0] OUTCOME_RIGHT   = 2'd2;
	localparam logic [1:0] OUTCOME_LEFT    = 2'd3;

	// request opcodes
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_POP   = 1'b1;

	// operation broadcast to every cell in a cycle
	typedef enum logic [2:0] {
		CELL_HOLD  = 3'd0,
		CELL_FILL  = 3'd1,
		CELL_RIGHT = 3'd2,
		CELL_LEFT  = 3'd3,
		CELL_POP   = 3'd4
	} cell_op_t;

	// one pool entry
	typedef struct packed {
		logic               valid;
		logic [SCORE_W-1:0] score;
		logic [KEY_W-1:0]   key;
		logic [DB_W-1:0]    db;
	} ecp_entry_t;

	// broadcast control from the top level to the cells
	typedef struct packed {
		cell_op_t           op;
		logic [SCORE_W-1:0] score;
		logic [KEY_W-1:0]   key;
		logic [DB_W-1:0]    db;
	} ecp_ctrl_t;

endpackage

`default_nettype wire

@@ src/ecp_cell.sv @@
// ecp_cell: one slot of the sorted candidate pool, talks to its two neighbors
// depends on ecp_pkg
`default_nettype none

module ecp_cell import ecp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ecp_ctrl_t  ctrl,
	input  wire ecp_entry_t left_entry,
	input  wire ecp_entry_t right_entry,
	input  wire logic       left_lt,
	input  wire logic       right_lt,
	output ecp_entry_t      entry,
	output logic            lt,
	output logic            ge,
	output ecp_entry_t      top_entry
);

	ecp_entry_t entry_q;
	ecp_entry_t entry_d;
	ecp_entry_t new_entry;
	logic       is_top;

	// compare against the offered score
	assign lt = entry_q.valid && (entry_q.score < ctrl.score);
	assign ge = entry_q.valid && !lt;

	// highest occupied slot: this one is valid and the right neighbor is not
	assign is_top    = entry_q.valid && !right_entry.valid;
	assign top_entry = is_top ? entry_q : '0;
	assign entry     = entry_q;

	assign new_entry = '{valid: 1'b1, score: ctrl.score, key: ctrl.key, db: ctrl.db};

	// next slot contents
	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			CELL_FILL: begin
				if (!entry_q.valid && left_entry.valid)
					entry_d = new_entry;
			end
			CELL_RIGHT: begin
				if (entry_q.valid && !lt && left_lt)
					entry_d = new_entry;
				else if (!left_lt)
					entry_d = left_entry;
			end
			CELL_LEFT: begin
				if (lt && !right_lt)
					entry_d = new_entry;
				else if (right_lt)
					entry_d = right_entry;
			end
			CELL_POP: begin
				if (is_top) begin
					entry_d.valid = 1'b0;
					entry_d.score = '0;
				end
			end
			default: entry_d = entry_q;
		endcase
	end

	// slot contents, empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_q <= '0;
		else
			entry_q <= entry_d;
	end

endmodule

`default_nettype wire

@@ src/eviction_candidate_pool.sv @@
// eviction_candidate_pool: sorted pool of eviction candidates built from a row of cells
// depends on ecp_pkg and ecp_cell
//
// channel   signals                      direction  payload
// in        in_valid / in_stall          input      opcode, key_handle, db_index, raw_age
// out       out_valid / out_stall        output     insert_outcome, found, out_key, out_db,
//                                                   out_score, occupancy
// cfg       cfg_valid / cfg_ready        input      cfg_lfu_mode
//
// one request per cycle unless in_stall; every cell compares against the offered score in
// parallel and the whole row shifts in the same edge, so the result is registered as the
// request is accepted. in_stall is high only while a result waits and out_stall holds it.
// reset empties the pool and clears the lfu mode; cfg_ready is always high.
`default_nettype none

module eviction_candidate_pool import ecp_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            opcode,
	input  wire logic [KEY_W-1:0]                key_handle,
	input  wire logic [DB_W-1:0]                 db_index,
	input  wire logic [SCORE_W-1:0]              raw_age,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           insert_outcome,
	output logic                                 found,
	output logic [KEY_W-1:0]                     out_key,
	output logic [DB_W-1:0]                      out_db,
	output logic [SCORE_W-1:0]                   out_score,
	output logic [$clog2(POOL_DEPTH+1)-1:0]      occupancy,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic                            cfg_lfu_mode
);

	localparam int CNT_W = $clog2(POOL_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_DEPTH);

	ecp_entry_t     cell_entry [POOL_DEPTH];
	ecp_entry_t     cell_top   [POOL_DEPTH];
	logic           cell_lt    [POOL_DEPTH];
	logic           cell_ge    [POOL_DEPTH];

	ecp_ctrl_t      ctrl;
	cell_op_t       cell_op;
	logic [SCORE_W-1:0] offer_score;
	ecp_entry_t     popped;
	logic           any_ge;
	logic           lfu_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic           accept;
	logic           full;
	logic           db_ok;
	logic [1:0]     outcome;
	logic           pop_found;
	logic           out_valid_q;
	logic [1:0]     outcome_q;
	logic           found_q;
	logic [KEY_W-1:0]   key_q;
	logic [DB_W-1:0]    db_q;
	logic [SCORE_W-1:0] score_q;
	logic [CNT_W-1:0]   occ_q;

	// handshakes
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lfu_q <= 1'b0;
		else if (cfg_valid)
			lfu_q <= cfg_lfu_mode;
	end

	// score of the offered candidate
	assign offer_score = lfu_q ? (LFU_INVERT_BASE - {24'd0, raw_age[7:0]}) : raw_age;
	assign ctrl = '{op: cell_op, score: offer_score, key: key_handle, db: db_index};

	// reductions over the row
	always_comb begin
		any_ge = 1'b0;
		popped = '0;
		for (int i = 0; i < POOL_DEPTH; i++) begin
			any_ge = any_ge | cell_ge[i];
			popped = popped | cell_top[i];
		end
	end

	// decide the operation for this beat
	assign full      = (count_q == FULL_CNT);
	assign db_ok     = (9'(db_index) < DB_COUNT);
	assign pop_found = (count_q != '0);

	always_comb begin
		outcome = OUTCOME_DROPPED;
		cell_op = CELL_HOLD;
		count_d = count_q;
		if (accept) begin
			if (opcode == OP_POP) begin
				if (pop_found) begin
					cell_op = CELL_POP;
					count_d = count_q - CNT_W'(1);
				end
			end else if (db_ok) begin
				if (full) begin
					if (cell_lt[0]) begin
						cell_op = CELL_LEFT;
						outcome = OUTCOME_LEFT;
					end
				end else if (any_ge) begin
					cell_op = CELL_RIGHT;
					outcome = OUTCOME_RIGHT;
					count_d = count_q + CNT_W'(1);
				end else begin
					cell_op = CELL_FILL;
					outcome = OUTCOME_EMPTY;
					count_d = count_q + CNT_W'(1);
				end
			end
		end
	end

	// row of cells
	for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
		ecp_entry_t left_e;
		ecp_entry_t right_e;
		logic       left_l;
		logic       right_l;

		if (i == 0) begin : g_lo
			assign left_e = '{valid: 1'b1, score: '0, key: '0, db: '0};
			assign left_l = 1'b1;
		end else begin : g_lo
			assign left_e = cell_entry[i-1];
			assign left_l = cell_lt[i-1];
		end

		if (i == POOL_DEPTH - 1) begin : g_hi
			assign right_e = '0;
			assign right_l = 1'b0;
		end else begin : g_hi
			assign right_e = cell_entry[i+1];
			assign right_l = cell_lt[i+1];
		end

		ecp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_entry (left_e),
			.right_entry(right_e),
			.left_lt    (left_l),
			.right_lt   (right_l),
			.entry      (cell_entry[i]),
			.lt         (cell_lt[i]),
			.ge         (cell_ge[i]),
			.top_entry  (cell_top[i])
		);
	end

	// occupancy counter and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_q <= outcome;
			occ_q     <= count_d;
			if (opcode == OP_POP) begin
				found_q <= pop_found;
				key_q   <= popped.key;
				db_q    <= popped.db;
				score_q <= popped.score;
			end else begin
				found_q <= 1'b0;
				key_q   <= '0;
				db_q    <= '0;
				score_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign insert_outcome = outcome_q;
	assign found          = found_q;
	assign out_key        = key_q;
	assign out_db         = db_q;
	assign out_score      = score_q;
	assign occupancy      = occ_q;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: self-checking bench for eviction_candidate_pool, predicts every result beat
// from its own copy of the sorted pool; depends on ecp_pkg and eviction_candidate_pool
`default_nettype none

module testbench;
	import ecp_pkg::*;

	localparam int DEPTH          = POOL_DEPTH_DEF;
	localparam int OCC_W          = $clog2(DEPTH + 1);
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// one predicted result beat
	typedef struct packed {
		logic [1:0]         outcome;
		logic               found;
		logic [KEY_W-1:0]   key;
		logic [DB_W-1:0]    db;
		logic [SCORE_W-1:0] score;
		logic [OCC_W-1:0]   occupancy;
	} pool_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               opcode       = OP_OFFER;
	logic [KEY_W-1:0]   key_handle   = '0;
	logic [DB_W-1:0]    db_index     = '0;
	logic [SCORE_W-1:0] raw_age      = '0;
	logic               out_stall    = 1'b0;
	logic               cfg_valid    = 1'b0;
	logic               cfg_lfu_mode = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [1:0]         insert_outcome;
	logic               found;
	logic [KEY_W-1:0]   out_key;
	logic [DB_W-1:0]    out_db;
	logic [SCORE_W-1:0] out_score;
	logic [OCC_W-1:0]   occupancy;
	logic               cfg_ready;

	// shadow pool and mode, advanced on every accepted beat
	ecp_entry_t   pool [DEPTH] = '{default: '0};
	logic         lfu_shadow   = 1'b0;
	pool_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles   = 0;
	int error_count   = 0;
	int outcome_count [4] = '{default: 0};
	int pops_found    = 0;
	int pops_empty    = 0;

	eviction_candidate_pool #(
		.POOL_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key_handle(key_handle),
		.db_index(db_index),
		.raw_age(raw_age),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.insert_outcome(insert_outcome),
		.found(found),
		.out_key(out_key),
		.out_db(out_db),
		.out_score(out_score),
		.occupancy(occupancy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_lfu_mode(cfg_lfu_mode)
	);

	always #HALF_PERIOD clk = ~clk;

	// random receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [OCC_W-1:0] occupied_count();
		int n;
		n = 0;
		foreach (pool[i])
			if (pool[i].valid)
				n++;
		return OCC_W'(n);
	endfunction

	// place a candidate in the sorted pool and report where it went
	function automatic pool_result_t offer_result(input logic [KEY_W-1:0] key,
			input logic [DB_W-1:0] db, input logic [SCORE_W-1:0] age);
		pool_result_t r;
		ecp_entry_t   fresh;
		int           k;
		r = '0;
		fresh.valid = 1'b1;
		fresh.score = lfu_shadow ? (LFU_INVERT_BASE - {24'd0, age[7:0]}) : age;
		fresh.key   = key;
		fresh.db    = db;
		k = 0;
		while (k < DEPTH && pool[k].valid && pool[k].score < fresh.score)
			k++;
		if ({5'd0, db} >= DB_COUNT) begin
			r.outcome = OUTCOME_DROPPED;
		end else if (k == 0 && pool[DEPTH-1].valid) begin
			r.outcome = OUTCOME_DROPPED;
		end else if (k < DEPTH && !pool[k].valid) begin
			pool[k]   = fresh;
			r.outcome = OUTCOME_EMPTY;
		end else if (!pool[DEPTH-1].valid) begin
			for (int i = DEPTH - 1; i > k; i--)
				pool[i] = pool[i-1];
			pool[k]   = fresh;
			r.outcome = OUTCOME_RIGHT;
		end else begin
			// full: everything below the slot moves down and the lowest falls out
			k--;
			for (int i = 0; i < k; i++)
				pool[i] = pool[i+1];
			pool[k]   = fresh;
			r.outcome = OUTCOME_LEFT;
		end
		r.occupancy = occupied_count();
		return r;
	endfunction

	// take the highest occupied slot
	function automatic pool_result_t pop_result();
		pool_result_t r;
		r = '0;
		for (int k = DEPTH - 1; k >= 0 && !r.found; k--) begin
			if (pool[k].valid) begin
				r.found       = 1'b1;
				r.key         = pool[k].key;
				r.db          = pool[k].db;
				r.score       = pool[k].score;
				pool[k].valid = 1'b0;
				pool[k].score = '0;
			end
		end
		r.occupancy = occupied_count();
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// predict on accepted requests, compare accepted result beats, count quiet cycles
	always @(posedge clk) begin
		pool_result_t want;
		bit           moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				lfu_shadow = cfg_lfu_mode;
				moved      = 1'b1;
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_OFFER) begin
					want = offer_result(key_handle, db_index, raw_age);
					outcome_count[want.outcome]++;
				end else begin
					want = pop_result();
					if (want.found)
						pops_found++;
					else
						pops_empty++;
				end
				pending_results.push_back(want);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					$error("result beat arrived with no expectation waiting");
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("insert_outcome", 32'(want.outcome), 32'(insert_outcome));
					check_field("found", 32'(want.found), 32'(found));
					check_field("out_key", want.key, out_key);
					check_field("out_db", 32'(want.db), 32'(out_db));
					check_field("out_score", want.score, out_score);
					check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on a stuck handshake
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [DB_W-1:0] db, input logic [SCORE_W-1:0] age);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		opcode     <= op;
		key_handle <= key;
		db_index   <= db;
		raw_age    <= age;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and wait until every predicted beat has come back
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lfu_mode(input logic mode);
		@(negedge clk);
		cfg_valid    <= 1'b1;
		cfg_lfu_mode <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_pop();
		send_item(OP_POP, '1, '1, '1);
	endtask

	// fill in idle mode, then overflow: ties, drop at the bottom, discard of the lowest
	task automatic test_fill_and_overflow();
		send_item(OP_OFFER, '0, '0, '0);
		send_item(OP_OFFER, '1, 4'd15, '1);
		send_item(OP_OFFER, 32'h1, 4'd1, '0);
		for (int i = 13; i >= 1; i--)
			send_item(OP_OFFER, $urandom(), 4'($urandom_range(15)), 32'(i * 100));
		send_item(OP_OFFER, 32'hDEAD_0000, 4'd2, '0);
		send_item(OP_OFFER, 32'hBEEF_0001, 4'd3, 32'd550);
		send_item(OP_OFFER, 32'h5A5A_A5A5, 4'd4, '1);
		repeat (3) send_item(OP_POP, $urandom(), 4'($urandom_range(15)), $urandom());
	endtask

	// lfu scoring: counter byte extremes with the upper bits both clear and set
	task automatic test_lfu_scores();
		settle();
		write_lfu_mode(1'b1);
		send_item(OP_OFFER, 32'h0000_0011, 4'd5, 32'h0000_0000);
		send_item(OP_OFFER, 32'h0000_0022, 4'd6, 32'hFFFF_FF00);
		send_item(OP_OFFER, 32'h0000_0033, 4'd7, 32'h0000_00FF);
	endtask

	// random offers and pops with the pop share changing every few dozen beats
	task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
		logic               op;
		logic [SCORE_W-1:0] age;
		int                 pop_bias;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		pop_bias      = 30;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				pop_bias = 15 + 30 * $urandom_range(2);
			op = ($urandom_range(99) < pop_bias) ? OP_POP : OP_OFFER;
			case ($urandom_range(9))
				0: age = '0;
				1: age = '1;
				// narrow range so that equal scores are common
				2, 3, 4: age = lfu_shadow ? (($urandom() & 32'hFFFF_FF00) | $urandom_range(8))
				                          : 32'($urandom_range(32));
				default: age = $urandom();
			endcase
			send_item(op, $urandom(), 4'($urandom_range(15)), age);
		end
	endtask

	initial begin
		send_idle_pct = 20;
		recv_idle_pct = 63;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_empty_pop();
		test_fill_and_overflow();
		test_lfu_scores();

		settle();
		write_lfu_mode(1'b0);
		test_random_phase(20, 63, 150);
		settle();
		write_lfu_mode(1'b1);
		test_random_phase(63, 20, 150);
		settle();
		write_lfu_mode(1'b0);
		test_random_phase(0, 0, 75);
		settle();
		write_lfu_mode(1'b1);
		test_random_phase(0, 0, 75);
		settle();

		$display("covered offers: %0d dropped, %0d into empty slot, %0d shifted right, %0d lowest discarded",
			outcome_count[OUTCOME_DROPPED], outcome_count[OUTCOME_EMPTY],
			outcome_count[OUTCOME_RIGHT], outcome_count[OUTCOME_LEFT]);
		$display("covered pops: %0d with entry, %0d on empty pool; idle and lfu scoring, three stall mixes",
			pops_found, pops_empty);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
